>>> rtl/ecpd_pkg.sv
// Shared types, codes and microcode program of the encoder speed PID controller.
`default_nettype none

package ecpd_pkg;

   localparam int STEP_W  = 4;
   localparam int GAIN_W  = 16;
   localparam int CNT_W   = 16;
   localparam int SP_W    = 23;
   localparam int SPEED_W = 22;
   localparam int DUTY_W  = 7;
   localparam int ERR_W   = 25;
   localparam int SUM_W   = 48;
   localparam int WIDE_W  = 64;
   localparam int DIV_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [WIDE_W-1:0] SPEED_MAX   = 64'd4194303;
   localparam logic [WIDE_W-1:0] ITERM_LIMIT = 64'h1000_0000_0000_0000;
   localparam logic [DUTY_W-1:0] DUTY_MAX    = 7'd95;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd2;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1280;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd26;

   // datapath register operations
   localparam logic [3:0] DP_NONE  = 4'd0;
   localparam logic [3:0] DP_MAG   = 4'd1;
   localparam logic [3:0] DP_KDT   = 4'd2;
   localparam logic [3:0] DP_SPEED = 4'd3;
   localparam logic [3:0] DP_ERR   = 4'd4;
   localparam logic [3:0] DP_ESUM  = 4'd5;
   localparam logic [3:0] DP_PTERM = 4'd6;
   localparam logic [3:0] DP_DTERM = 4'd7;
   localparam logic [3:0] DP_ILO   = 4'd8;
   localparam logic [3:0] DP_IHI   = 4'd9;
   localparam logic [3:0] DP_ITERM = 4'd10;
   localparam logic [3:0] DP_OUT   = 4'd11;

   // multiplier operand pairs
   localparam logic [2:0] MUL_NONE  = 3'd0;
   localparam logic [2:0] MUL_SPEED = 3'd1;
   localparam logic [2:0] MUL_KDT   = 3'd2;
   localparam logic [2:0] MUL_P     = 3'd3;
   localparam logic [2:0] MUL_D     = 3'd4;
   localparam logic [2:0] MUL_ILO   = 3'd5;
   localparam logic [2:0] MUL_IHI   = 3'd6;

   // divider launches
   localparam logic [1:0] DIV_NONE  = 2'd0;
   localparam logic [1:0] DIV_SPEED = 2'd1;
   localparam logic [1:0] DIV_INTEG = 2'd2;

   // jump conditions
   localparam logic [1:0] JC_NONE     = 2'd0;
   localparam logic [1:0] JC_DIV_BUSY = 2'd1;
   localparam logic [1:0] JC_OUT_BUSY = 2'd2;

   // program addresses that are jump targets
   localparam logic [STEP_W-1:0] STEP_NEXT     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_WAIT_SPD = 4'd4;
   localparam logic [STEP_W-1:0] STEP_WAIT_INT = 4'd13;
   localparam logic [STEP_W-1:0] STEP_OUT      = 4'd15;

   typedef struct packed {
      logic [3:0]        dp_op;
      logic [2:0]        mul_op;
      logic [1:0]        div_op;
      logic [1:0]        jmp_cond;
      logic [STEP_W-1:0] jmp_target;
      logic              last;
   } ucode_type;

   typedef struct packed {
      logic [3:0] dp_op;
      logic [2:0] mul_op;
      logic [1:0] div_op;
   } ctl_type;

   typedef struct packed {
      logic div_busy;
      logic out_blocked;
   } stat_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } gains_type;

   function automatic ucode_type ucode_fetch(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{DP_NONE, MUL_NONE, DIV_NONE, JC_NONE, STEP_NEXT, 1'b0};
      case (step)
         4'd0:  w = '{DP_MAG,   MUL_NONE,  DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd1:  w = '{DP_NONE,  MUL_SPEED, DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd2:  w = '{DP_NONE,  MUL_KDT,   DIV_SPEED, JC_NONE, STEP_NEXT, 1'b0};
         4'd3:  w = '{DP_KDT,   MUL_NONE,  DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd4:  w = '{DP_NONE,  MUL_NONE,  DIV_NONE,  JC_DIV_BUSY, STEP_WAIT_SPD, 1'b0};
         4'd5:  w = '{DP_SPEED, MUL_NONE,  DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd6:  w = '{DP_ERR,   MUL_NONE,  DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd7:  w = '{DP_ESUM,  MUL_P,     DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd8:  w = '{DP_PTERM, MUL_D,     DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd9:  w = '{DP_DTERM, MUL_ILO,   DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd10: w = '{DP_ILO,   MUL_IHI,   DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd11: w = '{DP_IHI,   MUL_NONE,  DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd12: w = '{DP_NONE,  MUL_NONE,  DIV_INTEG, JC_NONE, STEP_NEXT, 1'b0};
         4'd13: w = '{DP_NONE,  MUL_NONE,  DIV_NONE,  JC_DIV_BUSY, STEP_WAIT_INT, 1'b0};
         4'd14: w = '{DP_ITERM, MUL_NONE,  DIV_NONE,  JC_NONE, STEP_NEXT, 1'b0};
         4'd15: w = '{DP_OUT,   MUL_NONE,  DIV_NONE,  JC_OUT_BUSY, STEP_OUT, 1'b1};
         default: w = '{DP_NONE, MUL_NONE, DIV_NONE, JC_NONE, STEP_NEXT, 1'b0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ecpd_div.sv
// Unsigned 64 by 16 bit restoring divider, four quotient bits per cycle.
`default_nettype none

module ecpd_div
   import ecpd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WIDE_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]  divisor,
   output logic                   busy,
   output logic [WIDE_W-1:0]      quotient
);

   localparam int BITS_PER_CYC = 4;
   localparam int ITERS        = WIDE_W / BITS_PER_CYC;
   localparam int ITER_W       = $clog2(ITERS);

   logic              busy_ff, busy_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [WIDE_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]  dvsr_ff, dvsr_in;
   logic [DIV_W-1:0]  r;
   logic [WIDE_W-1:0] d;
   logic [DIV_W:0]    t;

   always_comb begin
      r = rem_ff;
      d = quo_ff;
      t = '0;
      for (int i = 0; i < BITS_PER_CYC; i++) begin
         t = {r, d[WIDE_W-1]};
         d = {d[WIDE_W-2:0], 1'b0};
         if (t >= {1'b0, dvsr_ff}) begin
            r    = DIV_W'(t - {1'b0, dvsr_ff});
            d[0] = 1'b1;
         end else begin
            r = t[DIV_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(ITERS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = d;
         if (iter_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            iter_in = iter_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not go busy after start");

endmodule

`default_nettype wire

>>> rtl/ecpd_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module ecpd_seq
   import ecpd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output logic          idle,
   output ctl_type       ctl
);

   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              taken;
   logic              issue;

   assign word  = ucode_fetch(step_ff);
   assign taken = ((word.jmp_cond == JC_DIV_BUSY) && stat.div_busy) ||
                  ((word.jmp_cond == JC_OUT_BUSY) && stat.out_blocked);
   assign issue = active_ff && !taken;

   always_comb begin
      ctl.dp_op  = issue ? word.dp_op  : DP_NONE;
      ctl.mul_op = issue ? word.mul_op : MUL_NONE;
      ctl.div_op = issue ? word.div_op : DIV_NONE;
   end

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      if (!active_ff) begin
         if (start) begin
            active_in = 1'b1;
            step_in   = '0;
         end
      end else if (taken) begin
         step_in = word.jmp_target;
      end else if (word.last) begin
         active_in = 1'b0;
         step_in   = '0;
      end else begin
         step_in = STEP_W'(step_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

   assign idle = !active_ff;

   a_start_step0: assert property (@(posedge clock) disable iff (reset)
      (start && !active_ff) |=> (active_ff && step_ff == '0))
      else $error("program did not start at step zero");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (active_ff && word.last && !taken) |=> !active_ff)
      else $error("program kept running past its last step");

endmodule

`default_nettype wire

>>> rtl/ecpd_dp.sv
// Datapath: input capture, shared multiplier, PID state and accumulator.
`default_nettype none

module ecpd_dp
   import ecpd_pkg::*;
#(
   parameter int COUNTS_PER_REV   = 13728,
   parameter int TICKS_PER_SECOND = 100
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              capture,
   input  wire logic [CNT_W-1:0]  cnt_in,
   input  wire logic [SP_W-1:0]   setpoint_in,
   input  wire logic              run_in,
   input  wire gains_type         gains,
   input  wire ctl_type           ctl,
   input  wire logic              div_busy,
   input  wire logic [WIDE_W-1:0] div_quo,
   output logic                   div_start,
   output logic [WIDE_W-1:0]      div_dividend,
   output logic [DIV_W-1:0]       div_divisor,
   output logic [DUTY_W-1:0]      duty,
   output logic                   running,
   output logic [SPEED_W-1:0]     speed
);

   localparam logic signed [31:0] SPEED_K = 32'(TICKS_PER_SECOND * 60 * 256);
   localparam logic signed [31:0] TPS_K   = 32'(TICKS_PER_SECOND);
   localparam logic [DIV_W-1:0]   CPR_DIV = DIV_W'(COUNTS_PER_REV);
   localparam logic [DIV_W-1:0]   TPS_DIV = DIV_W'(TICKS_PER_SECOND);

   // captured item
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [SP_W-1:0]   setpoint_ff;
   logic                     run_ff;

   // state kept across items
   logic [CNT_W-1:0]         prev_count_ff, prev_count_in;
   logic signed [ERR_W-1:0]  prev_err_ff, prev_err_in;
   logic signed [SUM_W-1:0]  esum_ff, esum_in;

   // working registers
   logic [CNT_W:0]           mag_ff, mag_in;
   logic [29:0]              kdt_ff, kdt_in;
   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W:0]    ediff_ff, ediff_in;
   logic [SUM_W-1:0]         smag_ff, smag_in;
   logic [WIDE_W-1:0]        iprod_ff, iprod_in;
   logic signed [WIDE_W-1:0] acc_ff, acc_in;
   logic signed [WIDE_W-1:0] prod_ff;

   logic signed [31:0]       mul_a, mul_b;
   logic signed [WIDE_W-1:0] mul_p;
   logic [CNT_W-1:0]         diff;
   logic signed [SUM_W:0]    sum_wide;
   logic [WIDE_W-1:0]        imag;
   logic signed [WIDE_W-1:0] iterm;
   logic [WIDE_W-17:0]       whole;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.mul_op)
         MUL_SPEED: begin
            mul_a = $signed({15'b0, mag_ff});
            mul_b = SPEED_K;
         end
         MUL_KDT: begin
            mul_a = $signed({16'b0, gains.deriv});
            mul_b = TPS_K;
         end
         MUL_P: begin
            mul_a = $signed({16'b0, gains.prop});
            mul_b = 32'(err_ff);
         end
         MUL_D: begin
            mul_a = $signed({2'b0, kdt_ff});
            mul_b = 32'(ediff_ff);
         end
         MUL_ILO: begin
            mul_a = $signed({16'b0, gains.integ});
            mul_b = $signed({8'b0, smag_ff[23:0]});
         end
         MUL_IHI: begin
            mul_a = $signed({16'b0, gains.integ});
            mul_b = $signed({8'b0, smag_ff[47:24]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign div_start    = (ctl.div_op == DIV_SPEED) || (ctl.div_op == DIV_INTEG);
   assign div_dividend = (ctl.div_op == DIV_INTEG) ? iprod_ff : WIDE_W'(prod_ff);
   assign div_divisor  = (ctl.div_op == DIV_INTEG) ? TPS_DIV : CPR_DIV;

   assign diff     = cnt_ff - prev_count_ff;
   assign sum_wide = {esum_ff[SUM_W-1], esum_ff} + (SUM_W+1)'(err_ff);
   assign imag     = (div_quo > ITERM_LIMIT) ? ITERM_LIMIT : div_quo;
   assign iterm    = esum_ff[SUM_W-1] ? -$signed(imag) : $signed(imag);

   always_comb begin
      prev_count_in = prev_count_ff;
      prev_err_in   = prev_err_ff;
      esum_in       = esum_ff;
      mag_in        = mag_ff;
      kdt_in        = kdt_ff;
      speed_in      = speed_ff;
      err_in        = err_ff;
      ediff_in      = ediff_ff;
      smag_in       = smag_ff;
      iprod_in      = iprod_ff;
      acc_in        = acc_ff;
      case (ctl.dp_op)
         DP_MAG: begin
            // half-range step keeps its full magnitude
            mag_in        = diff[CNT_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
            prev_count_in = cnt_ff;
         end
         DP_KDT: kdt_in = prod_ff[29:0];
         DP_SPEED: speed_in = (div_quo > SPEED_MAX) ? SPEED_MAX[SPEED_W-1:0]
                                                    : div_quo[SPEED_W-1:0];
         DP_ERR: err_in = ERR_W'(setpoint_ff) - $signed({3'b0, speed_ff});
         DP_ESUM: begin
            // saturate the integral on overflow of the 48-bit store
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
               esum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               esum_in = sum_wide[SUM_W-1:0];
            end
            ediff_in    = (ERR_W+1)'(err_ff) - (ERR_W+1)'(prev_err_ff);
            prev_err_in = err_ff;
         end
         DP_PTERM: begin
            acc_in  = prod_ff;
            smag_in = esum_ff[SUM_W-1] ? SUM_W'(~esum_ff + 1'b1) : esum_ff;
         end
         DP_DTERM: acc_in = acc_ff + prod_ff;
         DP_ILO: iprod_in = prod_ff;
         DP_IHI: iprod_in = iprod_ff + {prod_ff[39:0], 24'b0};
         DP_ITERM: acc_in = acc_ff + iterm;
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         prev_err_ff   <= '0;
         esum_ff       <= '0;
      end else begin
         prev_count_ff <= prev_count_in;
         prev_err_ff   <= prev_err_in;
         esum_ff       <= esum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         cnt_ff      <= cnt_in;
         setpoint_ff <= setpoint_in;
         run_ff      <= run_in;
      end
      prod_ff  <= mul_p;
      mag_ff   <= mag_in;
      kdt_ff   <= kdt_in;
      speed_ff <= speed_in;
      err_ff   <= err_in;
      ediff_ff <= ediff_in;
      smag_ff  <= smag_in;
      iprod_ff <= iprod_in;
      acc_ff   <= acc_in;
   end

   // clamp the Q.16 sum to the duty range
   assign whole = acc_ff[WIDE_W-1:16];

   always_comb begin
      if (acc_ff[WIDE_W-1] || acc_ff == '0 || !run_ff) begin
         duty = '0;
      end else if (whole > (WIDE_W-16)'(DUTY_MAX)) begin
         duty = DUTY_MAX;
      end else begin
         duty = whole[DUTY_W-1:0];
      end
   end

   assign running = run_ff;
   assign speed   = speed_ff;

   a_no_div_overlap: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider launched while still busy");

endmodule

`default_nettype wire

>>> rtl/encoder_speed_pid_duty_top.sv
// Top level of the encoder speed PID controller with duty output.
//
//   channel | ports                                   | direction | handshake
//   req     | encoder_count setpoint_rpm motor_on ... | in        | req_valid / req_ready
//   rsp     | duty running speed_rpm                  | out       | rsp_valid / rsp_ready
//   csr     | csr_index csr_wdata                     | in        | csr_we, no wait
//
// An item runs from its transfer through the program to its result register, and
// a new item is taken in the cycle after that register loads. The program waits
// on two passes of the shared divider (speed scaling, then the integral term).
// Reset clears the encoder history, stored error and integral, and restores the
// default gains.
// A result waiting on rsp_ready holds the program at its last step; the next
// item is taken only once that result has moved on to the output register.
`default_nettype none

module encoder_speed_pid_duty_top
   import ecpd_pkg::*;
#(
   parameter int COUNTS_PER_REV   = 13728,
   parameter int TICKS_PER_SECOND = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CNT_W-1:0]     req_encoder_count,
   input  wire logic [SP_W-1:0]      req_setpoint_rpm,
   input  wire logic                 req_motor_on,
   input  wire logic                 req_button_on,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DUTY_W-1:0]         rsp_duty,
   output logic                      rsp_running,
   output logic [SPEED_W-1:0]        rsp_speed_rpm,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata
);

   gains_type          gains_ff, gains_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]  duty_ff;
   logic               running_ff;
   logic [SPEED_W-1:0] speed_ff;

   logic               idle;
   logic               req_xfer;
   logic               load;
   ctl_type            ctl;
   stat_type           stat;
   logic               div_start;
   logic               div_busy;
   logic [WIDE_W-1:0]  div_dividend;
   logic [DIV_W-1:0]   div_divisor;
   logic [WIDE_W-1:0]  div_quo;
   logic [DUTY_W-1:0]  dp_duty;
   logic               dp_running;
   logic [SPEED_W-1:0] dp_speed;

   assign req_ready = idle;
   assign req_xfer  = req_valid && req_ready;

   assign stat.div_busy    = div_busy;
   assign stat.out_blocked = rsp_valid_ff && !rsp_ready;

   ecpd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_xfer),
      .stat  (stat),
      .idle  (idle),
      .ctl   (ctl)
   );

   ecpd_dp #(
      .COUNTS_PER_REV   (COUNTS_PER_REV),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .capture      (req_xfer),
      .cnt_in       (req_encoder_count),
      .setpoint_in  (req_setpoint_rpm),
      .run_in       (req_motor_on && req_button_on),
      .gains        (gains_ff),
      .ctl          (ctl),
      .div_busy     (div_busy),
      .div_quo      (div_quo),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .duty         (dp_duty),
      .running      (dp_running),
      .speed        (dp_speed)
   );

   ecpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROP_GAIN:  gains_in.prop  = csr_wdata;
            CSR_INTEG_GAIN: gains_in.integ = csr_wdata;
            CSR_DERIV_GAIN: gains_in.deriv = csr_wdata;
            default:        gains_in = gains_ff;
         endcase
      end
   end

   // output register: load on the last step, drop after the transfer
   assign load = (ctl.dp_op == DP_OUT);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff     <= '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST};
         rsp_valid_ff <= 1'b0;
      end else begin
         gains_ff     <= gains_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         duty_ff    <= dp_duty;
         running_ff <= dp_running;
         speed_ff   <= dp_speed;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duty      = duty_ff;
   assign rsp_running   = running_ff;
   assign rsp_speed_rpm = speed_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over one not yet transferred");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("input still ready after a transfer");

endmodule

`default_nettype wire
